// ----- design/dlpd_pkg.sv -----
// Shared constants, codes and types for the decimal length-prefix deframer.
package dlpd_pkg;

    // Width of the length accumulator and payload byte counter
    localparam int LEN_BITS      = 24;
    // Width of the max_length configuration register
    localparam int MAXLEN_BITS   = 24;
    // Width of a value built as accum*10 + digit
    localparam int PROD_BITS     = LEN_BITS + 4;
    // Compare width that holds both the product and the register
    localparam int CMP_BITS      = (PROD_BITS > MAXLEN_BITS) ? PROD_BITS : MAXLEN_BITS;

    localparam int DELIM_REPEATS = 5;
    localparam int POS_BITS      = 4;
    localparam logic [POS_BITS-1:0] DELIM_LAST_POS = POS_BITS'(2 * DELIM_REPEATS - 1);
    localparam logic [POS_BITS-1:0] DELIM_FIRST_POS = POS_BITS'(1);

    localparam logic [MAXLEN_BITS-1:0] MAXLEN_RESET = {MAXLEN_BITS{1'b1}};

    // Character codes
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_0  = 8'h30;
    localparam logic [7:0] CHAR_9  = 8'h39;

    // Input kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_LOST = 1'b1;

    // Parser phases
    localparam logic [1:0] PH_LEN   = 2'd0;
    localparam logic [1:0] PH_DELIM = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_DATA      = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_BAD_DELIM = 3'd2;
    localparam logic [2:0] ST_BAD_LEN   = 3'd3;
    localparam logic [2:0] ST_LOST      = 3'd4;

    // One result from the parser towards the output register
    typedef struct packed {
        logic       vld;
        logic [2:0] status;
        logic [7:0] payload_byte;
        logic       last;
    } dlpd_res_t;

endpackage

// ----- design/decimal_length_prefix_deframer.sv -----
// Top level of the decimal length-prefix deframer.
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata[7:0] rx_byte, tuser[0] kind
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata[7:0] payload_byte,
//                                                    tuser[2:0] status, tlast last
//  cfg       in         cfg_we                       cfg_wdata[23:0] max_length
//
// One transaction per cycle while s_axis_tready is high; a result appears in the
// cycle after the byte that causes it, set by the single result register after the parser logic.
// Reset clears the parser to the length phase and max_length to all ones.
// A stall on m_axis holds s_axis_tready low only while the result register
// is full and not being taken.
module decimal_length_prefix_deframer
    import dlpd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] rx_byte
    input  logic                   s_axis_tuser,   // [0] kind
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [7:0]             m_axis_tdata,   // [7:0] payload_byte
    output logic [2:0]             m_axis_tuser,   // [2:0] status
    output logic                   m_axis_tlast,
    input  logic                   cfg_we,
    input  logic [MAXLEN_BITS-1:0] cfg_wdata
);

    logic      accept;
    dlpd_res_t res;

    assign accept = s_axis_tvalid && s_axis_tready;

    // Frame parser
    dlpd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .kind      (s_axis_tuser),
        .rx_byte   (s_axis_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .res       (res)
    );

    // Result register
    dlpd_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .res        (res),
        .out_ready  (m_axis_tready),
        .in_ready   (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_status (m_axis_tuser),
        .out_byte   (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // Lost connection always yields its status in the next cycle
    a_lost_reported: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_axis_tuser == KIND_LOST |=> m_axis_tvalid && m_axis_tuser == ST_LOST)
        else $error("lost connection not reported");

    // Non-data results carry a zero byte
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != ST_DATA |-> m_axis_tdata == 8'd0)
        else $error("non-data result with non-zero byte");

    // last only on payload or empty frame
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == ST_DATA || m_axis_tuser == ST_EMPTY)
        else $error("last flag on error result");

    // Empty result register never blocks the input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");
`endif

endmodule

// ----- design/dlpd_parser.sv -----
// Frame parser: length digits, CR LF delimiter and payload byte count.
module dlpd_parser
    import dlpd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic                   kind,
    input  logic [7:0]             rx_byte,
    input  logic                   cfg_we,
    input  logic [MAXLEN_BITS-1:0] cfg_wdata,
    output dlpd_res_t              res
);

    logic [1:0]             phase_reg,     phase_next;
    logic [LEN_BITS-1:0]    accum_reg,     accum_next;
    logic                   seen_reg,      seen_next;
    logic [POS_BITS-1:0]    pos_reg,       pos_next;
    logic [LEN_BITS-1:0]    left_reg,      left_next;
    logic [MAXLEN_BITS-1:0] max_len_reg;

    logic [PROD_BITS-1:0]   accum_ext;
    logic [PROD_BITS-1:0]   prod;
    logic [7:0]             digit;
    logic                   is_digit;
    logic                   too_long;
    logic [LEN_BITS-1:0]    left_dec;
    logic [7:0]             want;

    // Length accumulate: accum*10 + digit, then range check
    assign digit     = rx_byte - CHAR_0;
    assign is_digit  = (rx_byte >= CHAR_0) && (rx_byte <= CHAR_9);
    assign accum_ext = PROD_BITS'(accum_reg);
    assign prod      = (accum_ext << 3) + (accum_ext << 1) + PROD_BITS'(digit[3:0]);
    assign too_long  = (CMP_BITS'(prod) > CMP_BITS'(max_len_reg))
                    || (CMP_BITS'(prod) > CMP_BITS'({LEN_BITS{1'b1}}));

    assign left_dec  = left_reg - LEN_BITS'(1);
    assign want      = pos_reg[0] ? CHAR_LF : CHAR_CR;

    // Next state and result
    always_comb
    begin
        phase_next = phase_reg;
        accum_next = accum_reg;
        seen_next  = seen_reg;
        pos_next   = pos_reg;
        left_next  = left_reg;
        res        = '0;

        if (kind == KIND_LOST)
        begin
            phase_next = PH_LEN;
            accum_next = '0;
            seen_next  = 1'b0;
            pos_next   = '0;
            left_next  = '0;
            res.vld    = 1'b1;
            res.status = ST_LOST;
        end
        else
        begin
            case (phase_reg)
                PH_DELIM:
                begin
                    if (rx_byte != want)
                    begin
                        phase_next = PH_LEN;
                        accum_next = '0;
                        seen_next  = 1'b0;
                        pos_next   = '0;
                        left_next  = '0;
                        res.vld    = 1'b1;
                        res.status = ST_BAD_DELIM;
                    end
                    else if (pos_reg != DELIM_LAST_POS)
                    begin
                        pos_next = pos_reg + POS_BITS'(1);
                    end
                    else if (accum_reg == '0)
                    begin
                        // zero length: empty frame
                        phase_next = PH_LEN;
                        seen_next  = 1'b0;
                        pos_next   = '0;
                        left_next  = '0;
                        res.vld    = 1'b1;
                        res.status = ST_EMPTY;
                        res.last   = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                        left_next  = accum_reg;
                        accum_next = '0;
                        seen_next  = 1'b0;
                        pos_next   = '0;
                    end
                end

                PH_DATA:
                begin
                    res.vld          = 1'b1;
                    res.status       = ST_DATA;
                    res.payload_byte = rx_byte;
                    left_next        = left_dec;
                    if (left_dec == '0)
                    begin
                        res.last   = 1'b1;
                        phase_next = PH_LEN;
                        accum_next = '0;
                        seen_next  = 1'b0;
                        pos_next   = '0;
                    end
                end

                default:
                begin
                    // length digits (unused phase code behaves the same)
                    if (is_digit && !too_long)
                    begin
                        phase_next = PH_LEN;
                        accum_next = prod[LEN_BITS-1:0];
                        seen_next  = 1'b1;
                    end
                    else if (!is_digit && rx_byte == CHAR_CR && seen_reg)
                    begin
                        phase_next = PH_DELIM;
                        pos_next   = DELIM_FIRST_POS;
                    end
                    else
                    begin
                        phase_next = PH_LEN;
                        accum_next = '0;
                        seen_next  = 1'b0;
                        pos_next   = '0;
                        left_next  = '0;
                        res.vld    = 1'b1;
                        res.status = ST_BAD_LEN;
                    end
                end
            endcase
        end
    end

    // State update on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEN;
            accum_reg <= '0;
            seen_reg  <= 1'b0;
            pos_reg   <= '0;
            left_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            seen_reg  <= seen_next;
            pos_reg   <= pos_next;
            left_reg  <= left_next;
        end
    end

    // Length limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAXLEN_RESET;
        else if (cfg_we)
            max_len_reg <= cfg_wdata;
    end

endmodule

// ----- design/dlpd_out_reg.sv -----
// Output register stage: holds one result until the downstream side takes it.
module dlpd_out_reg
    import dlpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  dlpd_res_t  res,
    input  logic       out_ready,
    output logic       in_ready,
    output logic       out_valid,
    output logic [2:0] out_status,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic       vld_reg,    vld_next;
    logic [2:0] status_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    // Free when empty or being drained this cycle
    assign in_ready = !vld_reg || out_ready;
    assign vld_next = in_ready ? (load && res.vld) : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_ready && load && res.vld)
        begin
            status_reg <= res.status;
            byte_reg   <= res.payload_byte;
            last_reg   <= res.last;
        end
    end

    assign out_valid  = vld_reg;
    assign out_status = status_reg;
    assign out_byte   = byte_reg;
    assign out_last   = last_reg;

endmodule

// ----- tb/decimal_length_prefix_deframer_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the decimal length-prefix deframer: directed frames, random traffic.
module decimal_length_prefix_deframer_test;
    import dlpd_pkg::*;

    // Cycles with no transaction on either side before the run is abandoned
    localparam int QUIET_LIMIT   = 5000;
    // Cycles left after the last result before a register write or the end
    localparam int SETTLE_CYCLES = 4;
    localparam int DELIM_BYTES   = 2 * DELIM_REPEATS;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        logic [2:0] status;
        logic [7:0] payload_byte;
        logic       last;
    } frame_res_t;

    // How a generated frame is spoiled, if at all
    typedef enum int {
        FAULT_NONE,
        FAULT_DELIM,
        FAULT_ANY_BYTE,
        FAULT_LOST
    } fault_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = '0;   // [7:0] rx_byte
    logic                   s_axis_tuser  = KIND_BYTE;   // [0] kind
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [7:0]             m_axis_tdata;   // [7:0] payload_byte
    logic [2:0]             m_axis_tuser;   // [2:0] status
    logic                   m_axis_tlast;
    logic                   cfg_we        = 1'b0;
    logic [MAXLEN_BITS-1:0] cfg_wdata     = '0;

    // Parser model state
    logic [1:0]             mdl_phase;
    logic [LEN_BITS-1:0]    mdl_accum;
    logic                   mdl_digit_seen;
    logic [POS_BITS-1:0]    mdl_pos;
    logic [LEN_BITS-1:0]    mdl_left;
    logic [MAXLEN_BITS-1:0] mdl_max_len = MAXLEN_RESET;
    frame_res_t             expected_results[$];
    frame_res_t             rx_want;

    int items_sent   = 0;
    int results_seen = 0;
    int cfg_writes   = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_req     = 0;
    int hold_left    = 0;
    int status_seen[5] = '{default: 0};

    decimal_length_prefix_deframer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ---------------------------------------------------------------- model

    function automatic void clear_parser();
        mdl_phase      = PH_LEN;
        mdl_accum      = '0;
        mdl_digit_seen = 1'b0;
        mdl_pos        = '0;
        mdl_left       = '0;
    endfunction

    function automatic void expect_result(input logic [2:0] status, input logic [7:0] b,
                                          input logic last);
        frame_res_t r;
        r.status       = status;
        r.payload_byte = b;
        r.last         = last;
        expected_results.push_back(r);
    endfunction

    // Advance the parser model by one accepted input transaction
    function automatic void parse_byte(input logic kind, input logic [7:0] b);
        logic [31:0] next_len;
        logic [7:0]  want;
        if (kind == KIND_LOST)
        begin
            clear_parser();
            expect_result(ST_LOST, 8'h00, 1'b0);
        end
        else if (mdl_phase == PH_DELIM)
        begin
            // odd positions want LF, even ones CR
            want = mdl_pos[0] ? CHAR_LF : CHAR_CR;
            if (b != want)
            begin
                clear_parser();
                expect_result(ST_BAD_DELIM, 8'h00, 1'b0);
            end
            else if (mdl_pos < DELIM_LAST_POS)
                mdl_pos = mdl_pos + 1'b1;
            else if (mdl_accum == '0)
            begin
                clear_parser();
                expect_result(ST_EMPTY, 8'h00, 1'b1);
            end
            else
            begin
                mdl_left       = mdl_accum;
                mdl_accum      = '0;
                mdl_digit_seen = 1'b0;
                mdl_pos        = '0;
                mdl_phase      = PH_DATA;
            end
        end
        else if (mdl_phase == PH_DATA)
        begin
            mdl_left = mdl_left - 1'b1;
            if (mdl_left == '0)
            begin
                clear_parser();
                expect_result(ST_DATA, b, 1'b1);
            end
            else
                expect_result(ST_DATA, b, 1'b0);
        end
        // length phase, unused phase code included
        else if (b >= CHAR_0 && b <= CHAR_9)
        begin
            next_len = 32'(mdl_accum) * 32'd10 + 32'(b - CHAR_0);
            if (next_len > 32'(mdl_max_len))
            begin
                clear_parser();
                expect_result(ST_BAD_LEN, 8'h00, 1'b0);
            end
            else
            begin
                mdl_phase      = PH_LEN;
                mdl_accum      = next_len[LEN_BITS-1:0];
                mdl_digit_seen = 1'b1;
            end
        end
        else if (b == CHAR_CR && mdl_digit_seen)
        begin
            mdl_phase = PH_DELIM;
            mdl_pos   = DELIM_FIRST_POS;
        end
        else
        begin
            clear_parser();
            expect_result(ST_BAD_LEN, 8'h00, 1'b0);
        end
    endfunction

    function automatic void report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch at %0t ns: %s", $time, msg);
    endfunction

    // ---------------------------------------------------------------- sender side

    // One input transaction, with random idle cycles in front of it
    task automatic send_item(input logic kind, input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        parse_byte(kind, b);
        items_sent++;
    endtask

    // First count bytes of the CR LF delimiter
    task automatic send_delimiter(input int count);
        for (int i = 0; i < count; i++)
            send_item(KIND_BYTE, i[0] ? CHAR_LF : CHAR_CR);
    endtask

    // Length field, delimiter and random payload; a length above the limit sends only
    // the digits, a fault replaces one transaction and ends the frame there
    task automatic send_frame(input int unsigned len, input int unsigned zeros,
                              input fault_t fault);
        logic [7:0]  head[$];
        int unsigned v;
        int unsigned body;
        int unsigned fault_at;
        int unsigned i;
        logic [7:0]  b;
        v = len;
        do
        begin
            head.push_front(CHAR_0 + 8'(v % 10));
            v = v / 10;
        end
        while (v != 0);
        repeat (zeros) head.push_front(CHAR_0);
        body = head.size();
        if (len <= 32'(mdl_max_len))
            body += DELIM_BYTES + len;
        case (fault)
            FAULT_NONE:  fault_at = body;
            FAULT_DELIM: fault_at = head.size() + $urandom_range(0, DELIM_BYTES - 1);
            default:     fault_at = $urandom_range(0, body - 1);
        endcase
        for (i = 0; i < body && i <= fault_at; i++)
        begin
            if (i < head.size())
                b = head[i];
            else if (i < head.size() + DELIM_BYTES)
                b = ((i - head.size()) % 2 != 0) ? CHAR_LF : CHAR_CR;
            else
                b = 8'($urandom_range(255));
            if (i != fault_at)
                send_item(KIND_BYTE, b);
            else if (fault == FAULT_LOST)
                send_item(KIND_LOST, 8'($urandom_range(255)));
            else
                send_item(KIND_BYTE, b ^ 8'($urandom_range(1, 255)));
        end
    endtask

    // Stop offering and wait until every expected result has been taken
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_length(input logic [MAXLEN_BITS-1:0] value);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mdl_max_len = value;
        cfg_writes++;
    endtask

    // ---------------------------------------------------------------- receiver side

    always @(posedge clk)
    begin
        // check the result taken at this edge
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result status %0d byte %02h last %0b",
                                          m_axis_tuser, m_axis_tdata, m_axis_tlast));
            else
            begin
                rx_want = expected_results.pop_front();
                status_seen[rx_want.status]++;
                if (m_axis_tuser !== rx_want.status || m_axis_tdata !== rx_want.payload_byte
                    || m_axis_tlast !== rx_want.last)
                    report_mismatch($sformatf(
                        "result %0d status %0d/%0d byte %02h/%02h last %0b/%0b (exp/got)",
                        results_seen, rx_want.status, m_axis_tuser, rx_want.payload_byte,
                        m_axis_tdata, rx_want.last, m_axis_tlast));
            end
        end
        // ready for the next edge: long hold-off if one is pending, else random
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("decimal_length_prefix_deframer_test: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // Length field errors under the reset limit, and a lost connection
    task automatic test_length_field();
        send_frame(32'd16777216, 0, FAULT_NONE);   // one above the largest length
        send_item(KIND_BYTE, 8'h3A);               // ':' just above the digits
        send_item(KIND_BYTE, 8'h2F);               // '/' just below the digits
        send_item(KIND_BYTE, CHAR_CR);             // CR with no digits
        send_item(KIND_BYTE, CHAR_LF);
        send_item(KIND_LOST, 8'hFF);
    endtask

    // Empty frame with leading zero, payload extremes, bad delimiter, lost before the first payload byte
    task automatic test_frame_shapes();
        send_frame(0, 1, FAULT_NONE);
        send_item(KIND_BYTE, CHAR_0);
        send_item(KIND_BYTE, 8'h33);
        send_delimiter(DELIM_BYTES);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'hFF);
        send_item(KIND_BYTE, CHAR_LF);
        send_item(KIND_BYTE, CHAR_0);
        send_delimiter(3);
        send_item(KIND_BYTE, CHAR_CR);             // LF wanted here
        send_frame(2, 0, FAULT_NONE);
        send_item(KIND_BYTE, 8'h31);
        send_delimiter(DELIM_BYTES);
        send_item(KIND_LOST, 8'h00);
    endtask

    // Limit register at zero, at a small value and back at its largest value
    task automatic test_limit_register();
        write_max_length('0);
        send_item(KIND_BYTE, 8'h31);
        send_frame(0, 2, FAULT_NONE);
        write_max_length(MAXLEN_BITS'(9));
        send_frame(9, 0, FAULT_NONE);
        send_frame(10, 0, FAULT_NONE);
        write_max_length(MAXLEN_RESET);
    endtask

    // Receiver holds off while the sender keeps offering, then the results drain
    task automatic test_backpressure();
        int saved_idle;
        saved_idle  = tx_idle_pct;
        tx_idle_pct = 0;
        hold_req    = 300;
        repeat (4) send_frame($urandom_range(5, 20), 0, FAULT_NONE);
        wait_for_results();
        tx_idle_pct = saved_idle;
    endtask

    // Mostly well-formed frames with random payload, plus broken frames and noise
    task automatic test_random_traffic(input int count);
        int          start_count;
        int unsigned pick;
        int unsigned len;
        int unsigned zeros;
        start_count = items_sent;
        while (items_sent - start_count < count)
        begin
            pick = $urandom_range(99);
            len  = $urandom_range(99);
            if (len < 10)
                len = 0;
            else if (len < 85)
                len = $urandom_range(1, 8);
            else if (len < 97)
                len = $urandom_range(9, 40);
            else
                len = $urandom_range(41, 200);
            if (len > 32'(mdl_max_len))
                len = mdl_max_len;
            zeros = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
            if (pick < 72)
                send_frame(len, zeros, FAULT_NONE);
            else if (pick < 80)
                send_frame(len, zeros, FAULT_DELIM);
            else if (pick < 86)
                send_frame(len, zeros, FAULT_LOST);
            else if (pick < 90)
                send_frame(len, zeros, FAULT_ANY_BYTE);
            else if (pick < 95)
                send_frame(32'(mdl_max_len) + 1 + $urandom_range(0, 50), zeros, FAULT_NONE);
            else
                send_item(($urandom_range(9) == 0) ? KIND_LOST : KIND_BYTE,
                          8'($urandom_range(255)));
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        clear_parser();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 32;
        rx_idle_pct = 48;
        test_length_field();
        test_frame_shapes();
        test_limit_register();
        test_random_traffic(130);

        tx_idle_pct = 48;
        rx_idle_pct = 32;
        write_max_length(MAXLEN_BITS'($urandom_range(20, 60)));
        test_random_traffic(130);
        test_backpressure();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_max_length(MAXLEN_BITS'($urandom_range(200, 100000)));
        test_random_traffic(130);
        wait_for_results();

        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        $display("covered %0d input transactions, %0d results, %0d max_length writes",
                 items_sent, results_seen, cfg_writes);
        $display("payload %0d, empty frame %0d, bad delimiter %0d, bad length %0d, lost %0d",
                 status_seen[ST_DATA], status_seen[ST_EMPTY], status_seen[ST_BAD_DELIM],
                 status_seen[ST_BAD_LEN], status_seen[ST_LOST]);
        if (mismatches == 0)
            $display("decimal_length_prefix_deframer_test: clean");
        else
            $display("decimal_length_prefix_deframer_test: errors");
        $finish;
    end

endmodule
